@@ rtl/lli_pkg.sv @@
// shared types and codes for the lift and latch interlock controller
package lli_pkg;

  // lift position codes
  typedef logic [1:0] lift_t;
  localparam lift_t LIFT_DEPLOYED  = 2'd0;
  localparam lift_t LIFT_RETRACTED = 2'd1;
  localparam lift_t LIFT_MOVING    = 2'd2;
  localparam lift_t LIFT_UNKNOWN   = 2'd3;

  // latch position codes
  typedef logic [1:0] latch_t;
  localparam latch_t LATCH_LOCKED   = 2'd0;
  localparam latch_t LATCH_UNLOCKED = 2'd1;
  localparam latch_t LATCH_UNKNOWN  = 2'd2;

  // opcodes
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE      = 3'd0;
  localparam op_t OP_RETRACT   = 3'd1;
  localparam op_t OP_DEPLOY    = 3'd2;
  localparam op_t OP_STOP      = 3'd3;
  localparam op_t OP_LIGHT_ON  = 3'd4;
  localparam op_t OP_LIGHT_OFF = 3'd5;

  // lift status codes
  typedef logic [2:0] status_t;
  localparam status_t STAT_DEPLOYED      = 3'd0;
  localparam status_t STAT_RET_UNLATCHED = 3'd1;
  localparam status_t STAT_RET_LATCHED   = 3'd2;
  localparam status_t STAT_LOWERING      = 3'd3;
  localparam status_t STAT_RAISING       = 3'd4;
  localparam status_t STAT_UNAVAILABLE   = 3'd5;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SETTLE_MS        = 3'd0;
  localparam cfg_idx_t CFG_DRIVE_LEVEL      = 3'd1;
  localparam cfg_idx_t CFG_RIGHT_LOCK_POS   = 3'd2;
  localparam cfg_idx_t CFG_LEFT_LOCK_POS    = 3'd3;
  localparam cfg_idx_t CFG_RIGHT_UNLOCK_POS = 3'd4;
  localparam cfg_idx_t CFG_LEFT_UNLOCK_POS  = 3'd5;

  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] SETTLE_MS_RST        = 16'd2000;
  localparam logic [6:0]  DRIVE_LEVEL_RST      = 7'd126;
  localparam logic [7:0]  RIGHT_LOCK_POS_RST   = 8'd140;
  localparam logic [7:0]  LEFT_LOCK_POS_RST    = 8'd32;
  localparam logic [7:0]  RIGHT_UNLOCK_POS_RST = 8'd100;
  localparam logic [7:0]  LEFT_UNLOCK_POS_RST  = 8'd65;

  typedef struct packed {
    logic [15:0] settle_ms;
    logic [6:0]  drive_level;
    logic [7:0]  right_lock_pos;
    logic [7:0]  left_lock_pos;
    logic [7:0]  right_unlock_pos;
    logic [7:0]  left_unlock_pos;
  } cfg_t;

  // controller state carried from one word to the next
  typedef struct packed {
    lift_t       lift_goal;
    latch_t      latch_pos;
    latch_t      latch_goal;
    latch_t      latch_cmd;
    logic [31:0] cmd_time;
    logic        light;
  } st_t;

  typedef struct packed {
    logic [7:0] motor_drive;
    logic [7:0] right_servo_pos;
    logic [7:0] left_servo_pos;
    logic       light_on;
    logic       docked;
    status_t    lift_status;
  } res_t;

endpackage

@@ rtl/lli_cfg.sv @@
// configuration register bank
module lli_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  lli_pkg::cfg_idx_t               cfg_index,
  input  logic [lli_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lli_pkg::cfg_t                   cfg_o
);

  lli_pkg::cfg_t cfg_r;
  lli_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lli_pkg::CFG_SETTLE_MS:        cfg_nxt.settle_ms        = cfg_data;
        lli_pkg::CFG_DRIVE_LEVEL:      cfg_nxt.drive_level      = cfg_data[6:0];
        lli_pkg::CFG_RIGHT_LOCK_POS:   cfg_nxt.right_lock_pos   = cfg_data[7:0];
        lli_pkg::CFG_LEFT_LOCK_POS:    cfg_nxt.left_lock_pos    = cfg_data[7:0];
        lli_pkg::CFG_RIGHT_UNLOCK_POS: cfg_nxt.right_unlock_pos = cfg_data[7:0];
        lli_pkg::CFG_LEFT_UNLOCK_POS:  cfg_nxt.left_unlock_pos  = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms        <= lli_pkg::SETTLE_MS_RST;
      cfg_r.drive_level      <= lli_pkg::DRIVE_LEVEL_RST;
      cfg_r.right_lock_pos   <= lli_pkg::RIGHT_LOCK_POS_RST;
      cfg_r.left_lock_pos    <= lli_pkg::LEFT_LOCK_POS_RST;
      cfg_r.right_unlock_pos <= lli_pkg::RIGHT_UNLOCK_POS_RST;
      cfg_r.left_unlock_pos  <= lli_pkg::LEFT_UNLOCK_POS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ rtl/lli_step.sv @@
// per-word interlock logic: next state and result from current state and inputs
module lli_step (
  input  lli_pkg::cfg_t   cfg,
  input  lli_pkg::st_t    st_cur,
  input  logic [31:0]     now_ms,
  input  logic            top_limit_n,
  input  logic            bottom_limit_n,
  input  logic            dock_beam,
  input  lli_pkg::op_t    opcode,
  output lli_pkg::st_t    st_nxt,
  output lli_pkg::res_t   res
);

  lli_pkg::lift_t  lift_pos;
  lli_pkg::latch_t latch_sw;
  lli_pkg::latch_t want;
  logic            cmd_en;
  logic [31:0]     elapsed;
  logic [7:0]      mag;

  always_comb begin
    st_nxt = st_cur;

    case (opcode)
      lli_pkg::OP_RETRACT: begin
        st_nxt.lift_goal  = lli_pkg::LIFT_RETRACTED;
        st_nxt.latch_goal = lli_pkg::LATCH_LOCKED;
        st_nxt.light      = 1'b0;
      end
      lli_pkg::OP_DEPLOY: begin
        st_nxt.lift_goal  = lli_pkg::LIFT_DEPLOYED;
        st_nxt.latch_goal = lli_pkg::LATCH_UNLOCKED;
        st_nxt.light      = 1'b1;
      end
      lli_pkg::OP_STOP:      st_nxt.light = 1'b0;
      lli_pkg::OP_LIGHT_ON:  st_nxt.light = 1'b1;
      lli_pkg::OP_LIGHT_OFF: st_nxt.light = 1'b0;
      default: ;
    endcase

    // top switch wins when both are pressed
    latch_sw = st_cur.latch_pos;
    if (!top_limit_n) begin
      lift_pos = lli_pkg::LIFT_RETRACTED;
    end else if (!bottom_limit_n) begin
      lift_pos = lli_pkg::LIFT_DEPLOYED;
      latch_sw = lli_pkg::LATCH_UNLOCKED;
    end else begin
      lift_pos = lli_pkg::LIFT_MOVING;
    end

    cmd_en = 1'b0;
    want   = st_nxt.latch_goal;
    if (latch_sw != st_nxt.latch_goal && st_nxt.latch_goal != lli_pkg::LATCH_UNKNOWN) begin
      cmd_en = (lift_pos == lli_pkg::LIFT_RETRACTED) ||
               (st_nxt.latch_goal == lli_pkg::LATCH_UNLOCKED);
    end else if (latch_sw == lli_pkg::LATCH_UNKNOWN) begin
      cmd_en = 1'b1;
      want   = lli_pkg::LATCH_UNLOCKED;
    end

    // settle timer restarts only on a change of the commanded latch
    if (cmd_en && st_cur.latch_cmd != want) begin
      st_nxt.latch_cmd = want;
      st_nxt.cmd_time  = now_ms;
    end

    elapsed = now_ms - st_nxt.cmd_time;
    st_nxt.latch_pos = latch_sw;
    if (elapsed > {16'd0, cfg.settle_ms}) begin
      st_nxt.latch_pos = st_nxt.latch_cmd;
    end

    mag = {1'b0, cfg.drive_level};
    res.motor_drive = 8'd0;
    if (st_nxt.lift_goal != lift_pos && st_nxt.lift_goal != lli_pkg::LIFT_UNKNOWN &&
        st_nxt.latch_pos == lli_pkg::LATCH_UNLOCKED) begin
      if (st_nxt.lift_goal == lli_pkg::LIFT_DEPLOYED) begin
        res.motor_drive = 8'd0 - mag;
      end else if (st_nxt.lift_goal == lli_pkg::LIFT_RETRACTED) begin
        res.motor_drive = mag;
      end
    end

    if (lift_pos == lli_pkg::LIFT_DEPLOYED) begin
      res.lift_status = lli_pkg::STAT_DEPLOYED;
    end else if (lift_pos == lli_pkg::LIFT_RETRACTED) begin
      if (st_nxt.latch_pos == lli_pkg::LATCH_UNLOCKED) begin
        res.lift_status = lli_pkg::STAT_RET_UNLATCHED;
      end else if (st_nxt.latch_pos == lli_pkg::LATCH_LOCKED) begin
        res.lift_status = lli_pkg::STAT_RET_LATCHED;
      end else begin
        res.lift_status = lli_pkg::STAT_UNAVAILABLE;
      end
    end else begin
      if (st_nxt.lift_goal == lli_pkg::LIFT_DEPLOYED) begin
        res.lift_status = lli_pkg::STAT_LOWERING;
      end else if (st_nxt.lift_goal == lli_pkg::LIFT_RETRACTED) begin
        res.lift_status = lli_pkg::STAT_RAISING;
      end else begin
        res.lift_status = lli_pkg::STAT_UNAVAILABLE;
      end
    end

    if (st_nxt.latch_cmd == lli_pkg::LATCH_LOCKED) begin
      res.right_servo_pos = cfg.right_lock_pos;
      res.left_servo_pos  = cfg.left_lock_pos;
    end else begin
      res.right_servo_pos = cfg.right_unlock_pos;
      res.left_servo_pos  = cfg.left_unlock_pos;
    end

    res.light_on = st_nxt.light;
    res.docked   = dock_beam;
  end

endmodule

@@ rtl/lift_latch_interlock_controller.sv @@
// Lift and latch interlock controller. Takes one input word per clock while in_stall
// is low and returns exactly one result word for each, offered from the result register
// after the word has passed the input register. The rate is one word per cycle when
// neither channel stalls: a word sits in the input register, passes once through the
// interlock logic, and lands in the result register at the same edge that updates the
// controller state. The result register and the input register together decouple the
// two channels, so while a finished result waits the empty input register can still
// take one word. No clearing pass after reset.
module lift_latch_interlock_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  lli_pkg::cfg_idx_t              cfg_index,
  input  logic [lli_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_now_ms,
  input  logic                           in_top_limit_n,
  input  logic                           in_bottom_limit_n,
  input  logic                           in_dock_beam,
  input  logic [2:0]                     in_opcode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [7:0]              out_motor_drive,
  output logic [7:0]                     out_right_servo_pos,
  output logic [7:0]                     out_left_servo_pos,
  output logic                           out_light_on,
  output logic                           out_docked,
  output logic [2:0]                     out_lift_status
);

  lli_pkg::cfg_t cfg;
  lli_pkg::st_t  st_r;
  lli_pkg::st_t  st_nxt;
  lli_pkg::res_t res_nxt;
  lli_pkg::res_t res_r;

  logic         s1_valid_r;
  logic [31:0]  s1_now_r;
  logic         s1_top_r;
  logic         s1_bot_r;
  logic         s1_dock_r;
  lli_pkg::op_t s1_op_r;
  logic         out_valid_r;
  logic         adv;
  logic         fire;

  lli_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // result register can take a word when empty or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_now_r  <= in_now_ms;
      s1_top_r  <= in_top_limit_n;
      s1_bot_r  <= in_bottom_limit_n;
      s1_dock_r <= in_dock_beam;
      s1_op_r   <= in_opcode;
    end
  end

  lli_step u_step (
    .cfg            (cfg),
    .st_cur         (st_r),
    .now_ms         (s1_now_r),
    .top_limit_n    (s1_top_r),
    .bottom_limit_n (s1_bot_r),
    .dock_beam      (s1_dock_r),
    .opcode         (s1_op_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.lift_goal  <= lli_pkg::LIFT_UNKNOWN;
      st_r.latch_pos  <= lli_pkg::LATCH_UNKNOWN;
      st_r.latch_goal <= lli_pkg::LATCH_UNKNOWN;
      st_r.latch_cmd  <= lli_pkg::LATCH_UNLOCKED;
      st_r.cmd_time   <= 32'd0;
      st_r.light      <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_drive     = res_r.motor_drive;
  assign out_right_servo_pos = res_r.right_servo_pos;
  assign out_left_servo_pos  = res_r.left_servo_pos;
  assign out_light_on        = res_r.light_on;
  assign out_docked          = res_r.docked;
  assign out_lift_status     = res_r.lift_status;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach result register");

  // motor may only run while the latch is open
  a_drive_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.motor_drive != 8'd0) |-> st_r.latch_pos == lli_pkg::LATCH_UNLOCKED)
    else $error("motor driven while latch not unlocked");

  a_timer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && st_nxt.latch_cmd != st_r.latch_cmd) |=> st_r.cmd_time == $past(s1_now_r))
    else $error("settle timer not restarted on latch command change");

endmodule

@@ test/lift_latch_interlock_controller_tb.sv @@
// self-checking testbench for the lift and latch interlock controller
module lift_latch_interlock_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // opcodes that the block ignores
  localparam lli_pkg::op_t OP_SPARE6 = 3'd6;
  localparam lli_pkg::op_t OP_SPARE7 = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int PLAN_LEN    = 21;
  localparam int PHASE_TICKS = 100;
  localparam int TOP_H       = 7;

  typedef struct {
    logic [31:0]   now;
    logic          top_n;
    logic          bot_n;
    logic          dock;
    lli_pkg::op_t  op;
    logic          typed;
    lli_pkg::res_t res;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  lli_pkg::cfg_idx_t cfg_index = lli_pkg::CFG_SETTLE_MS;
  logic [lli_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_now_ms = '0;
  logic in_top_limit_n = 1'b1;
  logic in_bottom_limit_n = 1'b1;
  logic in_dock_beam = 1'b0;
  logic [2:0] in_opcode = lli_pkg::OP_NONE;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [7:0] out_motor_drive;
  logic [7:0] out_right_servo_pos;
  logic [7:0] out_left_servo_pos;
  logic out_light_on;
  logic out_docked;
  logic [2:0] out_lift_status;

  // side band that travels with each offered word
  logic row_typed = 1'b0;
  lli_pkg::res_t row_res = '0;

  lift_latch_interlock_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_now_ms           (in_now_ms),
    .in_top_limit_n      (in_top_limit_n),
    .in_bottom_limit_n   (in_bottom_limit_n),
    .in_dock_beam        (in_dock_beam),
    .in_opcode           (in_opcode),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motor_drive     (out_motor_drive),
    .out_right_servo_pos (out_right_servo_pos),
    .out_left_servo_pos  (out_left_servo_pos),
    .out_light_on        (out_light_on),
    .out_docked          (out_docked),
    .out_lift_status     (out_lift_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller copy, register settings and state
  logic [15:0]     c_settle   = lli_pkg::SETTLE_MS_RST;
  logic [6:0]      c_drive    = lli_pkg::DRIVE_LEVEL_RST;
  logic [7:0]      c_rlock    = lli_pkg::RIGHT_LOCK_POS_RST;
  logic [7:0]      c_llock    = lli_pkg::LEFT_LOCK_POS_RST;
  logic [7:0]      c_runlock  = lli_pkg::RIGHT_UNLOCK_POS_RST;
  logic [7:0]      c_lunlock  = lli_pkg::LEFT_UNLOCK_POS_RST;
  lli_pkg::lift_t  pos_lift   = lli_pkg::LIFT_MOVING;
  lli_pkg::lift_t  goal_lift  = lli_pkg::LIFT_UNKNOWN;
  lli_pkg::latch_t pos_latch  = lli_pkg::LATCH_UNKNOWN;
  lli_pkg::latch_t goal_latch = lli_pkg::LATCH_UNKNOWN;
  lli_pkg::latch_t cmd_latch  = lli_pkg::LATCH_UNLOCKED;
  logic [31:0]     cmd_stamp  = '0;
  logic            lamp       = 1'b0;

  lli_pkg::res_t due_res[$];
  int n_ticks = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int quiet = 0;

  logic hold_req = 1'b0;
  logic src_calm = 1'b0;
  logic sink_calm = 1'b0;

  // stimulus plant: coarse lift height that follows the last deploy or retract
  int unsigned lift_h = 3;
  lli_pkg::op_t plant_goal = lli_pkg::OP_NONE;
  logic [31:0] clock_ms = '0;
  tick_row_t plan [PLAN_LEN];

  function automatic lli_pkg::res_t ctrl_tick(input logic [31:0] now, input logic top_n,
                                              input logic bot_n, input logic dock,
                                              input lli_pkg::op_t op);
    lli_pkg::res_t r;
    logic do_cmd;
    lli_pkg::latch_t want;
    logic [31:0] age;
    r = '0;
    case (op)
      lli_pkg::OP_RETRACT: begin
        goal_lift = lli_pkg::LIFT_RETRACTED;
        goal_latch = lli_pkg::LATCH_LOCKED;
        lamp = 1'b0;
      end
      lli_pkg::OP_DEPLOY: begin
        goal_lift = lli_pkg::LIFT_DEPLOYED;
        goal_latch = lli_pkg::LATCH_UNLOCKED;
        lamp = 1'b1;
      end
      lli_pkg::OP_STOP, lli_pkg::OP_LIGHT_OFF: lamp = 1'b0;
      lli_pkg::OP_LIGHT_ON: lamp = 1'b1;
      default: ;
    endcase

    // top switch wins when both are pressed
    if (!top_n) begin
      pos_lift = lli_pkg::LIFT_RETRACTED;
    end else if (!bot_n) begin
      pos_lift = lli_pkg::LIFT_DEPLOYED;
      pos_latch = lli_pkg::LATCH_UNLOCKED;
    end else begin
      pos_lift = lli_pkg::LIFT_MOVING;
    end

    do_cmd = 1'b0;
    want = lli_pkg::LATCH_UNLOCKED;
    if (pos_latch != goal_latch && goal_latch != lli_pkg::LATCH_UNKNOWN) begin
      if (pos_lift == lli_pkg::LIFT_RETRACTED || goal_latch == lli_pkg::LATCH_UNLOCKED) begin
        do_cmd = 1'b1;
        want = goal_latch;
      end
    end else if (pos_latch == lli_pkg::LATCH_UNKNOWN) begin
      do_cmd = 1'b1;
    end
    // settle timer restarts only on a change of the commanded latch
    if (do_cmd && cmd_latch != want) begin
      cmd_latch = want;
      cmd_stamp = now;
    end
    age = now - cmd_stamp;
    if (age > {16'd0, c_settle}) pos_latch = cmd_latch;

    if (goal_lift != pos_lift && goal_lift != lli_pkg::LIFT_UNKNOWN &&
        pos_latch == lli_pkg::LATCH_UNLOCKED) begin
      if (goal_lift == lli_pkg::LIFT_DEPLOYED) r.motor_drive = -{1'b0, c_drive};
      else if (goal_lift == lli_pkg::LIFT_RETRACTED) r.motor_drive = {1'b0, c_drive};
    end

    if (pos_lift == lli_pkg::LIFT_DEPLOYED) begin
      r.lift_status = lli_pkg::STAT_DEPLOYED;
    end else if (pos_lift == lli_pkg::LIFT_RETRACTED) begin
      if (pos_latch == lli_pkg::LATCH_UNLOCKED) r.lift_status = lli_pkg::STAT_RET_UNLATCHED;
      else if (pos_latch == lli_pkg::LATCH_LOCKED) r.lift_status = lli_pkg::STAT_RET_LATCHED;
      else r.lift_status = lli_pkg::STAT_UNAVAILABLE;
    end else begin
      if (goal_lift == lli_pkg::LIFT_DEPLOYED) r.lift_status = lli_pkg::STAT_LOWERING;
      else if (goal_lift == lli_pkg::LIFT_RETRACTED) r.lift_status = lli_pkg::STAT_RAISING;
      else r.lift_status = lli_pkg::STAT_UNAVAILABLE;
    end

    if (cmd_latch == lli_pkg::LATCH_LOCKED) begin
      r.right_servo_pos = c_rlock;
      r.left_servo_pos = c_llock;
    end else begin
      r.right_servo_pos = c_runlock;
      r.left_servo_pos = c_lunlock;
    end
    r.light_on = lamp;
    r.docked = dock;
    return r;
  endfunction

  function automatic tick_row_t mk_row(input logic [31:0] now, input logic top_n,
                                       input logic bot_n, input logic dock,
                                       input lli_pkg::op_t op, input logic typed,
                                       input lli_pkg::res_t res);
    tick_row_t t;
    t.now = now;
    t.top_n = top_n;
    t.bot_n = bot_n;
    t.dock = dock;
    t.op = op;
    t.typed = typed;
    t.res = res;
    return t;
  endfunction

  // prediction on input acceptance, comparison on output acceptance
  always @(posedge clk) begin : scoreboard
    lli_pkg::res_t want;
    lli_pkg::res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = ctrl_tick(in_now_ms, in_top_limit_n, in_bottom_limit_n, in_dock_beam,
                         lli_pkg::op_t'(in_opcode));
        if (row_typed) want = row_res;
        due_res.push_back(want);
        n_ticks++;
      end
      if (out_valid && !out_stall) begin
        got = {out_motor_drive, out_right_servo_pos, out_left_servo_pos,
               out_light_on, out_docked, out_lift_status};
        if (due_res.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("result %0d arrived with no word waiting", n_results);
          n_errors++;
        end else begin
          want = due_res.pop_front();
          if (got !== want) begin
            if (n_errors < MAX_REPORTS) begin
              $display("result %0d mismatch: want drive %0d rs %0d ls %0d light %b dock %b st %0d",
                       n_results, $signed(want.motor_drive), want.right_servo_pos,
                       want.left_servo_pos, want.light_on, want.docked, want.lift_status);
              $display("  got drive %0d rs %0d ls %0d light %b dock %b st %0d",
                       $signed(got.motor_drive), got.right_servo_pos, got.left_servo_pos,
                       got.light_on, got.docked, got.lift_status);
            end
            n_errors++;
          end
        end
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 33);
      end
    end
  end

  task automatic offer_tick(input logic [31:0] now, input logic top_n, input logic bot_n,
                            input logic dock, input lli_pkg::op_t op, input logic typed,
                            input lli_pkg::res_t res);
    in_valid <= 1'b1;
    in_now_ms <= now;
    in_top_limit_n <= top_n;
    in_bottom_limit_n <= bot_n;
    in_dock_beam <= dock;
    in_opcode <= op;
    row_typed <= typed;
    row_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    if (!src_calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // one edge first so the word taken at the last edge is already queued
  task automatic drain_results();
    @(posedge clk);
    while (due_res.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lli_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] settle, input logic [6:0] drive,
                               input logic [7:0] rl, input logic [7:0] ll,
                               input logic [7:0] ru, input logic [7:0] lu);
    in_valid <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    write_reg(lli_pkg::CFG_SETTLE_MS, settle);
    write_reg(lli_pkg::CFG_DRIVE_LEVEL, {9'd0, drive});
    write_reg(lli_pkg::CFG_RIGHT_LOCK_POS, {8'd0, rl});
    write_reg(lli_pkg::CFG_LEFT_LOCK_POS, {8'd0, ll});
    write_reg(lli_pkg::CFG_RIGHT_UNLOCK_POS, {8'd0, ru});
    write_reg(lli_pkg::CFG_LEFT_UNLOCK_POS, {8'd0, lu});
    cfg_we <= 1'b0;
    c_settle = settle;
    c_drive = drive;
    c_rlock = rl;
    c_llock = ll;
    c_runlock = ru;
    c_lunlock = lu;
    n_settings++;
  endtask

  // random words from a plant that mostly behaves like a real lift
  task automatic run_phase(input int count, input logic pause_mid);
    int k;
    int r;
    lli_pkg::op_t op;
    logic top_n;
    logic bot_n;
    for (k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) begin
        in_valid <= 1'b0;
        drain_results();
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 60) clock_ms = clock_ms + $urandom_range(0, 40);
      else if (r < 88) clock_ms = clock_ms + $urandom_range(0, c_settle + 60);
      else if (r < 94) clock_ms = clock_ms + c_settle + $urandom_range(0, 1);
      else clock_ms = $urandom();

      r = $urandom_range(0, 99);
      if (r < 66) op = lli_pkg::OP_NONE;
      else if (r < 75) op = lli_pkg::OP_DEPLOY;
      else if (r < 84) op = lli_pkg::OP_RETRACT;
      else if (r < 88) op = lli_pkg::OP_STOP;
      else if (r < 92) op = lli_pkg::OP_LIGHT_ON;
      else if (r < 96) op = lli_pkg::OP_LIGHT_OFF;
      else if (r < 98) op = OP_SPARE6;
      else op = OP_SPARE7;
      if (op == lli_pkg::OP_DEPLOY || op == lli_pkg::OP_RETRACT) plant_goal = op;

      if (plant_goal == lli_pkg::OP_RETRACT && lift_h < TOP_H && $urandom_range(0, 1) == 1)
        lift_h++;
      else if (plant_goal == lli_pkg::OP_DEPLOY && lift_h > 0 && $urandom_range(0, 1) == 1)
        lift_h--;
      top_n = (lift_h != TOP_H);
      bot_n = (lift_h != 0);
      // switch noise, both pressed included
      if ($urandom_range(0, 99) < 8) begin
        top_n = 1'($urandom_range(0, 1));
        bot_n = 1'($urandom_range(0, 1));
      end

      offer_tick(clock_ms, top_n, bot_n, 1'($urandom_range(0, 1)), op, 1'b0, '0);
      idle_gap();
    end
  endtask

  initial begin : stimulus
    int i;
    int p;
    plan[0]  = mk_row(32'd0, 1'b1, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd100, 8'd65, 1'b0, 1'b0,
                                       lli_pkg::STAT_UNAVAILABLE}));
    plan[1]  = mk_row(32'd2001, 1'b1, 1'b1, 1'b1, lli_pkg::OP_LIGHT_ON, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd100, 8'd65, 1'b1, 1'b1,
                                       lli_pkg::STAT_UNAVAILABLE}));
    plan[2]  = mk_row(32'd2002, 1'b1, 1'b0, 1'b0, lli_pkg::OP_DEPLOY, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd100, 8'd65, 1'b1, 1'b0,
                                       lli_pkg::STAT_DEPLOYED}));
    plan[3]  = mk_row(32'd2003, 1'b1, 1'b1, 1'b0, lli_pkg::OP_RETRACT, 1'b1,
                      lli_pkg::res_t'({8'd126, 8'd100, 8'd65, 1'b0, 1'b0,
                                       lli_pkg::STAT_RAISING}));
    plan[4]  = mk_row(32'd2010, 1'b0, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd140, 8'd32, 1'b0, 1'b0,
                                       lli_pkg::STAT_RET_UNLATCHED}));
    // exactly the settle time: not reached yet
    plan[5]  = mk_row(32'd4010, 1'b0, 1'b1, 1'b1, lli_pkg::OP_NONE, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd140, 8'd32, 1'b0, 1'b1,
                                       lli_pkg::STAT_RET_UNLATCHED}));
    plan[6]  = mk_row(32'd4011, 1'b0, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd140, 8'd32, 1'b0, 1'b0,
                                       lli_pkg::STAT_RET_LATCHED}));
    plan[7]  = mk_row(32'd4012, 1'b0, 1'b1, 1'b0, lli_pkg::OP_LIGHT_ON, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd140, 8'd32, 1'b1, 1'b0,
                                       lli_pkg::STAT_RET_LATCHED}));
    plan[8]  = mk_row(32'd4013, 1'b0, 1'b1, 1'b0, lli_pkg::OP_STOP, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd140, 8'd32, 1'b0, 1'b0,
                                       lli_pkg::STAT_RET_LATCHED}));
    // deploy while latched: motor held until the latch opens
    plan[9]  = mk_row(32'd4020, 1'b0, 1'b1, 1'b0, lli_pkg::OP_DEPLOY, 1'b1,
                      lli_pkg::res_t'({8'd0, 8'd100, 8'd65, 1'b1, 1'b0,
                                       lli_pkg::STAT_RET_LATCHED}));
    plan[10] = mk_row(32'd6021, 1'b0, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b1,
                      lli_pkg::res_t'({8'h82, 8'd100, 8'd65, 1'b1, 1'b0,
                                       lli_pkg::STAT_RET_UNLATCHED}));
    plan[11] = mk_row(32'd6022, 1'b0, 1'b0, 1'b1, lli_pkg::OP_NONE, 1'b0, '0);
    plan[12] = mk_row(32'd6030, 1'b1, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b0, '0);
    plan[13] = mk_row(32'd6040, 1'b1, 1'b0, 1'b0, OP_SPARE6, 1'b0, '0);
    plan[14] = mk_row(32'd6050, 1'b1, 1'b0, 1'b1, lli_pkg::OP_LIGHT_OFF, 1'b0, '0);
    // settle timer across the time wrap
    plan[15] = mk_row(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, lli_pkg::OP_RETRACT, 1'b0, '0);
    plan[16] = mk_row(32'hFFFF_FFF8, 1'b0, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b0, '0);
    plan[17] = mk_row(32'h0000_07C8, 1'b0, 1'b1, 1'b1, lli_pkg::OP_NONE, 1'b0, '0);
    plan[18] = mk_row(32'h0000_07C9, 1'b0, 1'b1, 1'b0, lli_pkg::OP_NONE, 1'b0, '0);
    plan[19] = mk_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, OP_SPARE7, 1'b0, '0);
    plan[20] = mk_row(32'd0, 1'b0, 1'b0, 1'b0, lli_pkg::OP_NONE, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < PLAN_LEN; i++) begin
      offer_tick(plan[i].now, plan[i].top_n, plan[i].bot_n, plan[i].dock, plan[i].op,
                 plan[i].typed, plan[i].res);
      idle_gap();
    end

    load_settings(16'd0, 7'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_phase(PHASE_TICKS, 1'b0);
    load_settings(16'hFFFF, 7'd127, 8'd180, 8'd180, 8'd180, 8'd180);
    run_phase(PHASE_TICKS, 1'b0);

    for (p = 2; p < 8; p++) begin
      load_settings((p == 5) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 400)),
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)));
      if (p == 3) begin
        // receiver holds off while words keep coming
        hold_req = 1'b1;
        src_calm = 1'b1;
      end
      if (p == 4) begin
        src_calm = 1'b1;
        sink_calm = 1'b1;
      end
      run_phase(PHASE_TICKS, p == 2);
      src_calm = 1'b0;
      sink_calm = 1'b0;
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    $display("%0d words and %0d results checked over %0d register settings", n_ticks,
             n_results, n_settings);
    $display("%0d mismatches, %0d results still due", n_errors, due_res.size());
    if (n_errors == 0 && due_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
